@@ rtl/mlfd_pkg.sv @@
// ----------------------------------------------------------------------------
// mlfd_pkg
// Shared types and constants for the marked-length frame deframer.
// ----------------------------------------------------------------------------
package mlfd_pkg;

  // Framing bytes and the per-frame byte overhead
  localparam logic [7:0]  START_MARK = 8'h02;
  localparam logic [7:0]  END_MARK   = 8'h03;
  localparam logic [15:0] OVERHEAD   = 16'd4;

  // Deframer phase
  typedef enum logic [2:0] {
    PH_HUNT    = 3'd0,
    PH_START   = 3'd1,
    PH_LEN_HI  = 3'd2,
    PH_LEN_LO  = 3'd3,
    PH_PAYLOAD = 3'd4,
    PH_END     = 3'd5
  } phase_t;

  // Result kinds
  typedef enum logic [2:0] {
    KIND_PAYLOAD   = 3'd0,
    KIND_COMPLETE  = 3'd1,
    KIND_BAD_START = 3'd2,
    KIND_SHORT_LEN = 3'd3,
    KIND_BAD_END   = 3'd4
  } kind_t;

  // One result item
  typedef struct packed {
    kind_t       kind;
    logic [7:0]  payload_data;
    logic [15:0] payload_offset;
    logic [15:0] payload_length;
  } result_t;

  // Result handed from the parser to the output buffer
  typedef struct packed {
    logic    valid;
    result_t res;
  } push_t;

endpackage

@@ rtl/mlfd_byte_if.sv @@
// ----------------------------------------------------------------------------
// mlfd_byte_if
// Valid/ready channel carrying one received byte.
// ----------------------------------------------------------------------------
interface mlfd_byte_if;
  logic       valid;
  logic       ready;
  logic [7:0] rx_byte;

  modport source (output valid, output rx_byte, input ready);
  modport sink   (input valid, input rx_byte, output ready);
endinterface

@@ rtl/mlfd_result_if.sv @@
// ----------------------------------------------------------------------------
// mlfd_result_if
// Valid/ready channel carrying one deframer result.
// ----------------------------------------------------------------------------
interface mlfd_result_if;
  logic                 valid;
  logic                 ready;
  mlfd_pkg::kind_t      kind;
  logic [7:0]           payload_data;
  logic [15:0]          payload_offset;
  logic [15:0]          payload_length;

  modport source (output valid, output kind, output payload_data,
                  output payload_offset, output payload_length, input ready);
  modport sink   (input valid, input kind, input payload_data,
                  input payload_offset, input payload_length, output ready);
endinterface

@@ rtl/mlfd_parser.sv @@
// ----------------------------------------------------------------------------
// mlfd_parser
// Frame state tracker: advances phase, length and byte count per byte and
// forms at most one result for each accepted byte.
// ----------------------------------------------------------------------------
module mlfd_parser (
  input  logic            clk,
  input  logic            rst,
  input  logic            step,
  input  logic [7:0]      rx_byte,
  output mlfd_pkg::push_t push
);

  mlfd_pkg::phase_t phase, phase_next;
  logic [15:0]      frame_length, frame_length_next;
  logic [15:0]      bytes_seen, bytes_seen_next;

  logic [15:0] len_lo;
  logic [15:0] seen_inc;
  logic [15:0] len_less1;

  assign len_lo    = {frame_length[15:8], rx_byte};
  assign seen_inc  = bytes_seen + 16'd1;
  assign len_less1 = frame_length - 16'd1;

  // Decode one byte against the current phase
  always_comb begin
    phase_next        = phase;
    frame_length_next = frame_length;
    bytes_seen_next   = bytes_seen;
    push              = '0;
    unique case (phase)
      mlfd_pkg::PH_START: begin
        if (rx_byte == mlfd_pkg::START_MARK) begin
          phase_next      = mlfd_pkg::PH_LEN_HI;
          bytes_seen_next = 16'd1;
        end else begin
          phase_next         = mlfd_pkg::PH_HUNT;
          bytes_seen_next    = '0;
          push.valid         = 1'b1;
          push.res.kind      = mlfd_pkg::KIND_BAD_START;
        end
      end
      mlfd_pkg::PH_LEN_HI: begin
        frame_length_next = {rx_byte, 8'h00};
        bytes_seen_next   = 16'd2;
        phase_next        = mlfd_pkg::PH_LEN_LO;
      end
      mlfd_pkg::PH_LEN_LO: begin
        frame_length_next = len_lo;
        bytes_seen_next   = 16'd3;
        if (len_lo < mlfd_pkg::OVERHEAD) begin
          phase_next      = mlfd_pkg::PH_HUNT;
          bytes_seen_next = '0;
          push.valid      = 1'b1;
          push.res.kind   = mlfd_pkg::KIND_SHORT_LEN;
        end else if (len_lo == mlfd_pkg::OVERHEAD) begin
          phase_next = mlfd_pkg::PH_END;
        end else begin
          phase_next = mlfd_pkg::PH_PAYLOAD;
        end
      end
      mlfd_pkg::PH_PAYLOAD: begin
        bytes_seen_next         = seen_inc;
        if (seen_inc >= len_less1) begin
          phase_next = mlfd_pkg::PH_END;
        end
        push.valid              = 1'b1;
        push.res.kind           = mlfd_pkg::KIND_PAYLOAD;
        push.res.payload_data   = rx_byte;
        push.res.payload_offset = bytes_seen - 16'd3;
      end
      mlfd_pkg::PH_END: begin
        bytes_seen_next = '0;
        push.valid      = 1'b1;
        if (rx_byte == mlfd_pkg::END_MARK) begin
          phase_next              = mlfd_pkg::PH_START;
          push.res.kind           = mlfd_pkg::KIND_COMPLETE;
          push.res.payload_length = frame_length - mlfd_pkg::OVERHEAD;
        end else begin
          phase_next    = mlfd_pkg::PH_HUNT;
          push.res.kind = mlfd_pkg::KIND_BAD_END;
        end
      end
      default: begin
        // Hunting: wait for a start mark, drop anything else
        if (rx_byte == mlfd_pkg::START_MARK) begin
          phase_next      = mlfd_pkg::PH_LEN_HI;
          bytes_seen_next = 16'd1;
        end else begin
          phase_next      = mlfd_pkg::PH_HUNT;
          bytes_seen_next = '0;
        end
      end
    endcase
    if (!step) begin
      push.valid = 1'b0;
    end
  end

  // Advance frame state on each accepted byte
  always_ff @(posedge clk) begin
    if (rst) begin
      phase        <= mlfd_pkg::PH_HUNT;
      frame_length <= '0;
      bytes_seen   <= '0;
    end else if (step) begin
      phase        <= phase_next;
      frame_length <= frame_length_next;
      bytes_seen   <= bytes_seen_next;
    end
  end

endmodule

@@ rtl/mlfd_out_buf.sv @@
// ----------------------------------------------------------------------------
// mlfd_out_buf
// Output register with a skid stage, so a byte can be taken while a result
// waits on the output.
// ----------------------------------------------------------------------------
module mlfd_out_buf (
  input  logic              clk,
  input  logic              rst,
  input  mlfd_pkg::push_t   push,
  output logic              can_take,
  mlfd_result_if.source     res
);

  logic              out_valid;
  mlfd_pkg::result_t out_res;
  logic              skid_valid;
  mlfd_pkg::result_t skid_res;
  logic              pop;

  assign pop      = out_valid && res.ready;
  assign can_take = !skid_valid;

  // Hold, shift or load the two result slots
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid  <= 1'b0;
      skid_valid <= 1'b0;
    end else if (pop) begin
      if (skid_valid) begin
        out_res <= skid_res;
        if (push.valid) begin
          skid_res <= push.res;
        end else begin
          skid_valid <= 1'b0;
        end
      end else if (push.valid) begin
        out_res <= push.res;
      end else begin
        out_valid <= 1'b0;
      end
    end else if (push.valid) begin
      if (!out_valid) begin
        out_res   <= push.res;
        out_valid <= 1'b1;
      end else begin
        skid_res   <= push.res;
        skid_valid <= 1'b1;
      end
    end
  end

  assign res.valid          = out_valid;
  assign res.kind           = out_res.kind;
  assign res.payload_data   = out_res.payload_data;
  assign res.payload_offset = out_res.payload_offset;
  assign res.payload_length = out_res.payload_length;

endmodule

@@ rtl/marked_length_frame_deframer.sv @@
// ----------------------------------------------------------------------------
// marked_length_frame_deframer
// Splits a byte stream into STX / length / payload / ETX frames.
// ----------------------------------------------------------------------------
// Takes one byte per cycle while rx.ready is high and gives at most one
// registered result per accepted byte: each payload byte with its offset,
// a frame complete result with the payload length, or an error (bad start
// byte, length below four, missing end mark), after which it hunts for 0x02.
// Throughput is one byte per clock while rx.ready is high; the frame state
// updates per accepted byte and a two-entry output buffer lets input go on
// while one result stalls. rx.ready drops only while both entries are full.
// ----------------------------------------------------------------------------
module marked_length_frame_deframer (
  input  logic          clk,
  input  logic          rst,
  mlfd_byte_if.sink     rx,
  mlfd_result_if.source res
);

  logic            can_take;
  logic            step;
  mlfd_pkg::push_t push;

  assign rx.ready = can_take;
  assign step     = rx.valid && can_take;

  // Frame state and result decode
  mlfd_parser u_parser (
    .clk     (clk),
    .rst     (rst),
    .step    (step),
    .rx_byte (rx.rx_byte),
    .push    (push)
  );

  // Result register and skid stage
  mlfd_out_buf u_out_buf (
    .clk      (clk),
    .rst      (rst),
    .push     (push),
    .can_take (can_take),
    .res      (res)
  );

endmodule
